// ===== rtl/core/pwce_pkg.sv =====
`default_nettype none
package pwce_pkg;

  localparam int unsigned DUR_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_TICKS  = 2'd2;

  localparam logic [DUR_W-1:0] SHORT_TICKS_RST = 16'd50;
  localparam logic [DUR_W-1:0] LONG_TICKS_RST  = 16'd100;
  localparam logic [DUR_W-1:0] TAIL_TICKS_RST  = 16'd400;

  // One classified byte as handed from the front end to the sequencer.
  typedef struct packed {
    logic [BYTE_W-1:0] cmd_byte;
    logic              frame_end;
    logic              start;
    logic              parity;
  } pwce_entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/pwce_front.sv =====
`default_nettype none
module pwce_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [pwce_pkg::BYTE_W-1:0] s_tdata,   // cmd_byte
  input  wire logic                       s_tlast,   // frame_end
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output pwce_pkg::pwce_entry_t           push_entry
);
  import pwce_pkg::*;

  logic in_frame;
  logic accept;

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign accept     = s_tvalid && push_ready;

  always_comb begin
    push_entry.cmd_byte  = s_tdata;
    push_entry.frame_end = s_tlast;
    push_entry.start     = ~in_frame;
    push_entry.parity    = ^s_tdata;
  end

  // A byte that does not close its frame leaves the next one inside the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else if (accept) begin
      in_frame <= ~s_tlast;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pwce_queue.sv =====
`default_nettype none
module pwce_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  wire pwce_pkg::pwce_entry_t push_entry,
  output logic                       pop_valid,
  input  wire logic                  pop_ready,
  output pwce_pkg::pwce_entry_t      pop_entry
);
  import pwce_pkg::*;

  pwce_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pwce_back.sv =====
`default_nettype none
module pwce_back #(
  parameter int unsigned PREAMBLE_PAIRS = 9
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pop_valid,
  output logic                            pop_ready,
  input  wire pwce_pkg::pwce_entry_t      pop_entry,
  input  wire logic [pwce_pkg::DUR_W-1:0] short_ticks,
  input  wire logic [pwce_pkg::DUR_W-1:0] long_ticks,
  input  wire logic [pwce_pkg::DUR_W-1:0] tail_ticks,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [pwce_pkg::DUR_W-1:0]      m_tdata,   // duration
  output logic                            m_tlast,   // run_last
  output logic                            m_tuser    // frame_done
);
  import pwce_pkg::*;

  localparam int unsigned CNT_W = $clog2(2 * PREAMBLE_PAIRS + 17);
  localparam logic [CNT_W-1:0] PRE_END  = CNT_W'(2 * PREAMBLE_PAIRS - 1);
  localparam logic [CNT_W-1:0] DATA_END = CNT_W'(15);
  localparam logic [CNT_W-1:0] PAR_END  = CNT_W'(1);

  typedef enum logic [2:0] {
    PH_START,
    PH_PREAMBLE,
    PH_DATA,
    PH_PARITY,
    PH_TAIL
  } phase_t;

  phase_t            phase;
  logic              busy;
  logic [CNT_W-1:0]  cnt;
  pwce_entry_t       cur;
  logic              adv;
  logic              is_final;
  logic              load;
  logic [DUR_W-1:0]  dur;

  // One duration per cycle moves into the output register whenever it is
  // empty or being drained.
  assign adv = busy && (!m_tvalid || m_tready);

  always_comb begin
    is_final = 1'b0;
    case (phase)
      PH_PARITY: is_final = (cnt == PAR_END) && !cur.frame_end;
      PH_TAIL:   is_final = 1'b1;
      default:   is_final = 1'b0;
    endcase
  end

  assign load      = pop_valid && (!busy || (adv && is_final));
  assign pop_ready = !busy || (adv && is_final);

  always_comb begin
    case (phase)
      PH_START:    dur = long_ticks;
      PH_PREAMBLE: dur = short_ticks;
      PH_DATA:     dur = cur.cmd_byte[cnt[3:1]] ? long_ticks : short_ticks;
      PH_PARITY:   dur = cur.parity ? long_ticks : short_ticks;
      PH_TAIL:     dur = tail_ticks;
      default:     dur = short_ticks;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      busy     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= 1'b1;
        m_tdata  <= dur;
        m_tlast  <= is_final;
        m_tuser  <= (phase == PH_TAIL);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (load) begin
        cur   <= pop_entry;
        busy  <= 1'b1;
        cnt   <= '0;
        phase <= pop_entry.start ? PH_START : PH_DATA;
      end else if (adv) begin
        case (phase)
          PH_START: begin
            cnt   <= '0;
            phase <= (PREAMBLE_PAIRS > 0) ? PH_PREAMBLE : PH_DATA;
          end
          PH_PREAMBLE: begin
            if (cnt == PRE_END) begin
              cnt   <= '0;
              phase <= PH_DATA;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          PH_DATA: begin
            if (cnt == DATA_END) begin
              cnt   <= '0;
              phase <= PH_PARITY;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          PH_PARITY: begin
            if (cnt == PAR_END) begin
              cnt <= '0;
              if (cur.frame_end) begin
                phase <= PH_TAIL;
              end else begin
                busy <= 1'b0;
              end
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          PH_TAIL: begin
            busy <= 1'b0;
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pulse_width_command_encoder.sv =====
`default_nettype none
// Pulse-width command encoder: each byte accepted on the s_ side becomes a
// run of timer durations on the m_ side, one duration per cycle while m_tready
// is high. A byte inside a frame gives 18 durations (eight bit pairs, least
// significant bit first, then an even-parity pair); the first byte of a frame
// adds one long start half and 2*PREAMBLE_PAIRS short halves (37 in all at the
// default, 38 for a frame of a single byte), and a byte with s_tlast set adds
// one tail duration, marked on m_tuser. m_tlast marks the last duration of
// each byte. Once started, the sequencer issues one duration per cycle while the
// output is not stalled, with no gap between bytes; a byte that reaches an idle
// sequencer passes through the queue, the sequencer's byte register and the output
// register before its first duration shows. A two-entry queue lets the input side
// accept bytes while the sequencer is still emitting earlier ones. Register writes
// take effect at once and should be made only while no byte is in flight.
module pulse_width_command_encoder #(
  parameter int unsigned PREAMBLE_PAIRS = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] cmd_byte
  input  wire logic                          s_tlast,   // frame_end
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [15:0]                        m_tdata,   // [15:0] duration
  output logic                               m_tlast,   // run_last
  output logic                               m_tuser,   // [0] frame_done
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pwce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import pwce_pkg::*;

  logic [DUR_W-1:0] short_ticks;
  logic [DUR_W-1:0] long_ticks;
  logic [DUR_W-1:0] tail_ticks;

  logic        push_valid;
  logic        push_ready;
  pwce_entry_t push_entry;
  logic        pop_valid;
  logic        pop_ready;
  pwce_entry_t pop_entry;

  assign cfg_ready = 1'b1;

  // An index beyond the register list is accepted and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= SHORT_TICKS_RST;
      long_ticks  <= LONG_TICKS_RST;
      tail_ticks  <= TAIL_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHORT_TICKS: short_ticks <= cfg_data;
        REG_LONG_TICKS:  long_ticks  <= cfg_data;
        REG_TAIL_TICKS:  tail_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pwce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  pwce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  pwce_back #(
    .PREAMBLE_PAIRS (PREAMBLE_PAIRS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_entry   (pop_entry),
    .short_ticks (short_ticks),
    .long_ticks  (long_ticks),
    .tail_ticks  (tail_ticks),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pwce_checker.sv =====
`default_nettype none
module pwce_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser,
  input wire logic        cfg_ready
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result payload changed while stalled");

  // The tail duration is always the final duration of its byte.
  a_tail_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end flagged on a duration that does not end its byte");

  // Reset leaves nothing on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  // Register writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind pulse_width_command_encoder pwce_checker u_pwce_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== tb/sv/pwce_checker.sv =====
`timescale 1ns / 100ps

module pwce_tb_checker #(
  parameter int unsigned PREAMBLE_PAIRS = 9
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [7:0]                     s_tdata,   // [7:0] cmd_byte
  input  wire logic                           s_tlast,   // frame_end
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [15:0]                    m_tdata,   // [15:0] duration
  input  wire logic                           m_tlast,   // run_last
  input  wire logic                           m_tuser,   // [0] frame_done
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [pwce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  typedef struct packed {
    logic [pwce_pkg::DUR_W-1:0] duration;
    logic                       run_last;
    logic                       frame_done;
  } pulse_half_t;

  pulse_half_t                expected_halves[$];
  logic [pwce_pkg::DUR_W-1:0] short_ticks;
  logic [pwce_pkg::DUR_W-1:0] long_ticks;
  logic [pwce_pkg::DUR_W-1:0] tail_ticks;
  logic                       in_frame;
  int                         halves_seen;

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) begin
      $display("mismatch at %0t ns, duration %0d: %s", $time, halves_seen, msg);
    end
    fail_count++;
  endtask

  function automatic void push_half(input logic [pwce_pkg::DUR_W-1:0] d,
                                    input logic fin, input logic done);
    pulse_half_t h;
    h.duration   = d;
    h.run_last   = fin;
    h.frame_done = done;
    expected_halves.push_back(h);
  endfunction

  // Expands one command byte into the durations it causes, in line order.
  function automatic void encode_byte(input logic [7:0] b, input logic last);
    logic [pwce_pkg::DUR_W-1:0] d;
    if (!in_frame) begin
      push_half(long_ticks, 1'b0, 1'b0);
      for (int i = 0; i < 2 * PREAMBLE_PAIRS; i++) begin
        push_half(short_ticks, 1'b0, 1'b0);
      end
    end
    for (int i = 0; i < 8; i++) begin
      d = b[i] ? long_ticks : short_ticks;
      push_half(d, 1'b0, 1'b0);
      push_half(d, 1'b0, 1'b0);
    end
    // Even parity: a long pair when the byte holds an odd count of ones.
    d = (^b) ? long_ticks : short_ticks;
    push_half(d, 1'b0, 1'b0);
    push_half(d, !last, 1'b0);
    if (last) begin
      push_half(tail_ticks, 1'b1, 1'b1);
    end
    in_frame = !last;
  endfunction

  always @(posedge clk) begin
    pulse_half_t want;
    if (rst) begin
      short_ticks = pwce_pkg::SHORT_TICKS_RST;
      long_ticks  = pwce_pkg::LONG_TICKS_RST;
      tail_ticks  = pwce_pkg::TAIL_TICKS_RST;
      in_frame    = 1'b0;
      halves_seen = 0;
      expected_halves.delete();
    end else begin
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        if (expected_halves.size() == 0) begin
          report_mismatch($sformatf("got %0d with nothing expected", m_tdata));
        end else begin
          want = expected_halves.pop_front();
          if (m_tdata !== want.duration) begin
            report_mismatch($sformatf("duration %0d, expected %0d", m_tdata, want.duration));
          end
          if (m_tlast !== want.run_last) begin
            report_mismatch($sformatf("run_last %b, expected %b", m_tlast, want.run_last));
          end
          if (m_tuser !== want.frame_done) begin
            report_mismatch($sformatf("frame_done %b, expected %b", m_tuser, want.frame_done));
          end
        end
        halves_seen++;
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          pwce_pkg::REG_SHORT_TICKS: short_ticks = cfg_data;
          pwce_pkg::REG_LONG_TICKS:  long_ticks  = cfg_data;
          pwce_pkg::REG_TAIL_TICKS:  tail_ticks  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
        encode_byte(s_tdata, s_tlast);
      end
    end
    pending = expected_halves.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned PREAMBLE = 9;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [pwce_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata   = 8'h00;  // [7:0] cmd_byte
  logic                           s_tlast   = 1'b0;   // frame_end
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [15:0]                    m_tdata;            // [15:0] duration
  logic                           m_tlast;            // run_last
  logic                           m_tuser;            // [0] frame_done
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pwce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                    cfg_data  = 16'h0000;

  int   fail_count;
  int   pending;
  logic hold_output = 1'b0;
  logic calm        = 1'b0;
  int   bytes_sent;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pulse_width_command_encoder #(.PREAMBLE_PAIRS(PREAMBLE)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pwce_tb_checker #(.PREAMBLE_PAIRS(PREAMBLE)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offers one byte and returns once the transaction has taken place; valid
  // is left high so that a following byte goes out without a gap.
  task automatic offer_byte(input logic [7:0] b, input logic last);
    s_tdata  <= b;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [pwce_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_ticks(input logic [15:0] short_t, input logic [15:0] long_t,
                           input logic [15:0] tail_t);
    write_reg(pwce_pkg::REG_SHORT_TICKS, short_t);
    write_reg(pwce_pkg::REG_LONG_TICKS, long_t);
    write_reg(pwce_pkg::REG_TAIL_TICKS, tail_t);
    write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame();
    int          len;
    logic [7:0]  b;
    len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (!calm && $urandom_range(0, 3) == 0) begin
        pause_sender($urandom_range(1, 19));
      end
      offer_byte(b, i == len - 1);
    end
  endtask

  // Receiver: bursts of ready and stall, plus one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    bytes_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Single-byte frames and a few short frames at the reset settings.
    offer_byte(8'h00, 1'b1);
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h01, 1'b0);
    offer_byte(8'h80, 1'b0);
    offer_byte(8'hA5, 1'b1);
    offer_byte(8'h7F, 1'b0);
    offer_byte(8'hFE, 1'b1);
    wait_drained();

    // A zero register is used as it stands.
    set_ticks(16'd0, 16'hFFFF, 16'd1);
    offer_byte(8'h55, 1'b0);
    offer_byte(8'hAA, 1'b1);
    offer_byte(8'h0F, 1'b1);
    wait_drained();
    set_ticks(16'hFFFF, 16'd0, 16'd0);
    offer_byte(8'hF0, 1'b0);
    offer_byte(8'h3C, 1'b0);
    offer_byte(8'hC3, 1'b1);
    wait_drained();
    set_ticks(16'd1, 16'd1, 16'hFFFF);
    offer_byte(8'h96, 1'b1);
    wait_drained();

    // Hold the output back while bytes keep coming, so the input stalls.
    hold_output = 1'b1;
    for (int i = 0; i < 6; i++) begin
      offer_byte(8'($urandom_range(0, 255)), i == 5);
    end
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       set_ticks(16'd1, 16'hFFFF, 16'hFFFF);
        2:       set_ticks(16'hFFFF, 16'd1, 16'd1);
        3:       set_ticks(pwce_pkg::SHORT_TICKS_RST, pwce_pkg::LONG_TICKS_RST,
                           pwce_pkg::TAIL_TICKS_RST);
        default: set_ticks(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
      endcase
      calm = (phase == 5);
      bytes_sent = 0;
      while (bytes_sent < 64) begin
        send_frame();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
